@@ sv/length_prefixed_frame_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Length-prefixed frame parser assertion macros
// Shared concurrent assertion forms for the frame parser checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LPFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication, disabled while reset is low.
`define LPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

@@ sv/lpfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed frame parser package
// Field and status codes, register indexes, defaults and the queue item type.
// ----------------------------------------------------------------------------
package lpfp_pkg;

    localparam int unsigned DEF_MAGIC_BYTES      = 4;
    localparam int unsigned DEF_SESSION_BYTES    = 16;
    localparam int unsigned DEF_NONCE_BYTES      = 12;
    localparam int unsigned DEF_TAG_BYTES        = 16;
    localparam int unsigned DEF_MAC_BYTES        = 32;
    localparam int unsigned DEF_MAX_PAYLOAD_LOG2 = 20;

    localparam int unsigned LEN_W       = 32;
    localparam int unsigned OUT_OFF_W   = 20;
    localparam logic [OUT_OFF_W-1:0] OUT_OFF_MAX = '1;
    localparam int unsigned CFG_W       = 32;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Fixed field sizes
    localparam int unsigned VERSION_BYTES = 1;
    localparam int unsigned TYPE_BYTES    = 1;
    localparam int unsigned COUNTER_BYTES = 8;
    localparam int unsigned LENGTH_BYTES  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'b1;

    typedef enum logic [3:0] {
        F_MAGIC   = 4'd0,
        F_VERSION = 4'd1,
        F_TYPE    = 4'd2,
        F_SESSION = 4'd3,
        F_COUNTER = 4'd4,
        F_NONCE   = 4'd5,
        F_LENGTH  = 4'd6,
        F_PAYLOAD = 4'd7,
        F_TAG     = 4'd8,
        F_MAC     = 4'd9,
        F_EXCESS  = 4'd10
    } t_field_code;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_TRUNC     = 3'd5,
        ST_TRAILING  = 3'd6
    } t_status;

    typedef struct packed {
        t_field_code          field_code;
        logic [OUT_OFF_W-1:0] field_offset;
        logic [7:0]           byte_out;
        logic                 frame_end;
        t_status              status;
    } t_item;

endpackage

@@ sv/length_prefixed_frame_parser_unit.sv @@
// An accepted byte goes into the queue, then into the output register when that is free.
// Throughput: one byte per cycle while o_stall is low; field and offset counters update per byte.
// A four-entry queue before the output register absorbs output stalls before input stalls.
// Reset (synchronous, active low) clears registers, parse state, queue and output valid.
// ----------------------------------------------------------------------------
// Length-prefixed frame parser
// Labels each frame byte with its field and offset and reports frame status.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_unit #(
    parameter int unsigned MAGIC_BYTES      = lpfp_pkg::DEF_MAGIC_BYTES,
    parameter int unsigned SESSION_BYTES    = lpfp_pkg::DEF_SESSION_BYTES,
    parameter int unsigned NONCE_BYTES      = lpfp_pkg::DEF_NONCE_BYTES,
    parameter int unsigned TAG_BYTES        = lpfp_pkg::DEF_TAG_BYTES,
    parameter int unsigned MAC_BYTES        = lpfp_pkg::DEF_MAC_BYTES,
    parameter int unsigned MAX_PAYLOAD_LOG2 = lpfp_pkg::DEF_MAX_PAYLOAD_LOG2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_frame_last,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [3:0]                         o_field_code,
    output logic [lpfp_pkg::OUT_OFF_W-1:0]     o_field_offset,
    output logic [7:0]                         o_byte_out,
    output logic                               o_frame_end,
    output logic [2:0]                         o_status,
    input  logic                               i_cfg_wr_en,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpfp_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import lpfp_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_front_item;
    t_item w_q_item;
    t_item w_out_item;

    assign o_stall = w_full;

    lpfp_front #(
        .MAGIC_BYTES      (MAGIC_BYTES),
        .SESSION_BYTES    (SESSION_BYTES),
        .NONCE_BYTES      (NONCE_BYTES),
        .TAG_BYTES        (TAG_BYTES),
        .MAC_BYTES        (MAC_BYTES),
        .MAX_PAYLOAD_LOG2 (MAX_PAYLOAD_LOG2)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_full       (w_full),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_push       (w_push),
        .o_item       (w_front_item)
    );

    lpfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    lpfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .i_stall   (i_stall),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .o_item    (w_out_item)
    );

    assign o_field_code   = w_out_item.field_code;
    assign o_field_offset = w_out_item.field_offset;
    assign o_byte_out     = w_out_item.byte_out;
    assign o_frame_end    = w_out_item.frame_end;
    assign o_status       = w_out_item.status;

endmodule

@@ sv/lpfp_front.sv @@
// ----------------------------------------------------------------------------
// Frame parser front end
// Accepts frame bytes, tracks field and offset, checks magic and version,
// and produces one labeled item per byte for the queue.
// ----------------------------------------------------------------------------
module lpfp_front #(
    parameter int unsigned MAGIC_BYTES      = lpfp_pkg::DEF_MAGIC_BYTES,
    parameter int unsigned SESSION_BYTES    = lpfp_pkg::DEF_SESSION_BYTES,
    parameter int unsigned NONCE_BYTES      = lpfp_pkg::DEF_NONCE_BYTES,
    parameter int unsigned TAG_BYTES        = lpfp_pkg::DEF_TAG_BYTES,
    parameter int unsigned MAC_BYTES        = lpfp_pkg::DEF_MAC_BYTES,
    parameter int unsigned MAX_PAYLOAD_LOG2 = lpfp_pkg::DEF_MAX_PAYLOAD_LOG2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_full,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_frame_last,
    input  logic                               i_cfg_wr_en,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpfp_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                               o_push,
    output lpfp_pkg::t_item                    o_item
);
    import lpfp_pkg::*;

    localparam int unsigned OFF_W =
        ((MAX_PAYLOAD_LOG2 > OUT_OFF_W) ? MAX_PAYLOAD_LOG2 : OUT_OFF_W) + 1;
    localparam int unsigned MIN_SIZE = MAGIC_BYTES + VERSION_BYTES + TYPE_BYTES
        + SESSION_BYTES + COUNTER_BYTES + NONCE_BYTES + LENGTH_BYTES
        + TAG_BYTES + MAC_BYTES;
    localparam int unsigned TOT_W = $clog2(MIN_SIZE + 1);
    localparam logic [TOT_W-1:0] TOT_MIN = TOT_W'(MIN_SIZE);
    localparam logic [LEN_W-1:0] PAY_LIMIT =
        {{(LEN_W-1){1'b0}}, 1'b1} << MAX_PAYLOAD_LOG2;
    localparam logic [2:0] MAGIC_LAST = 3'(MAGIC_BYTES - 1);

    logic [31:0]      r_exp_magic;
    logic [7:0]       r_exp_version;
    t_field_code      r_field,       n_field;
    logic [OFF_W-1:0] r_off,         n_off;
    logic [LEN_W-1:0] r_len,         n_len;
    logic [TOT_W-1:0] r_total,       n_total;
    logic             r_magic_bad,   n_magic_bad;
    logic             r_version_bad, n_version_bad;

    logic [OFF_W-1:0] w_off_inc;
    logic [LEN_W-1:0] w_size;
    logic [2:0]       w_pos;
    logic [7:0]       w_want;
    logic             w_field_done;
    logic             w_mac_done;
    logic             w_excess;
    t_status          w_status;

    assign o_push = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MAGIC:   r_exp_magic   <= i_cfg_wdata[31:0];
                CFG_VERSION: r_exp_version <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_field)
            F_MAGIC:   w_size = LEN_W'(MAGIC_BYTES);
            F_VERSION: w_size = LEN_W'(VERSION_BYTES);
            F_TYPE:    w_size = LEN_W'(TYPE_BYTES);
            F_SESSION: w_size = LEN_W'(SESSION_BYTES);
            F_COUNTER: w_size = LEN_W'(COUNTER_BYTES);
            F_NONCE:   w_size = LEN_W'(NONCE_BYTES);
            F_LENGTH:  w_size = LEN_W'(LENGTH_BYTES);
            F_PAYLOAD: w_size = r_len;
            F_TAG:     w_size = LEN_W'(TAG_BYTES);
            F_MAC:     w_size = LEN_W'(MAC_BYTES);
            default:   w_size = '0;
        endcase
    end

    always_comb begin
        w_off_inc = r_off + OFF_W'(1);
        w_excess  = (r_field >= F_EXCESS);

        // magic goes out most significant byte first; bytes past 32 bits expect zero
        w_pos  = MAGIC_LAST - r_off[2:0];
        w_want = w_pos[2] ? 8'h00 : r_exp_magic[{w_pos[1:0], 3'b000} +: 8];

        n_magic_bad   = r_magic_bad   || ((r_field == F_MAGIC)   && (w_want != i_data_byte));
        n_version_bad = r_version_bad || ((r_field == F_VERSION) && (r_exp_version != i_data_byte));
        n_len         = (r_field == F_LENGTH) ? {r_len[LEN_W-9:0], i_data_byte} : r_len;
        n_total       = (r_total < TOT_MIN) ? r_total + TOT_W'(1) : r_total;

        w_field_done = !w_excess && (LEN_W'(w_off_inc) >= w_size);
        w_mac_done   = w_field_done && (r_field == F_MAC);

        n_field = r_field;
        if (w_excess) begin
            n_off = (&r_off) ? r_off : w_off_inc;
        end else if (w_field_done) begin
            n_off = '0;
            if ((r_field == F_LENGTH) && (n_len > PAY_LIMIT)) begin
                n_field = F_EXCESS;
            end else if ((r_field == F_LENGTH) && (n_len == '0)) begin
                n_field = F_TAG;
            end else begin
                n_field = t_field_code'(r_field + 4'd1);
            end
        end else begin
            n_off = w_off_inc;
        end

        if (!i_frame_last)           w_status = ST_OK;
        else if (n_total < TOT_MIN)  w_status = ST_SHORT;
        else if (n_magic_bad)        w_status = ST_MAGIC;
        else if (n_version_bad)      w_status = ST_VERSION;
        else if (n_len > PAY_LIMIT)  w_status = ST_TOO_LARGE;
        else if (w_excess)           w_status = ST_TRAILING;
        else if (w_mac_done)         w_status = ST_OK;
        else                         w_status = ST_TRUNC;
    end

    always_comb begin
        o_item.field_code   = r_field;
        o_item.field_offset = (r_off > OFF_W'(OUT_OFF_MAX)) ? OUT_OFF_MAX
                                                            : r_off[OUT_OFF_W-1:0];
        o_item.byte_out     = i_data_byte;
        o_item.frame_end    = i_frame_last;
        o_item.status       = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field       <= F_MAGIC;
            r_off         <= '0;
            r_len         <= '0;
            r_total       <= '0;
            r_magic_bad   <= 1'b0;
            r_version_bad <= 1'b0;
        end else if (o_push) begin
            if (i_frame_last) begin
                // drop all frame state; registers stay
                r_field       <= F_MAGIC;
                r_off         <= '0;
                r_len         <= '0;
                r_total       <= '0;
                r_magic_bad   <= 1'b0;
                r_version_bad <= 1'b0;
            end else begin
                r_field       <= n_field;
                r_off         <= n_off;
                r_len         <= n_len;
                r_total       <= n_total;
                r_magic_bad   <= n_magic_bad;
                r_version_bad <= n_version_bad;
            end
        end
    end

endmodule

@@ sv/lpfp_queue.sv @@
// ----------------------------------------------------------------------------
// Frame parser item queue
// Short FIFO between front end and output stage.
// ----------------------------------------------------------------------------
module lpfp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpfp_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output lpfp_pkg::t_item o_item
);
    import lpfp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/lpfp_back.sv @@
// ----------------------------------------------------------------------------
// Frame parser output stage
// Pulls items from the queue into the output register and holds them
// while the receiver stalls.
// ----------------------------------------------------------------------------
module lpfp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  lpfp_pkg::t_item i_q_item,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output lpfp_pkg::t_item o_item
);
    import lpfp_pkg::*;

    logic  r_valid;
    t_item r_item;

    // load when the register is empty or its item leaves this cycle
    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
    end

endmodule

@@ sv/lpfp_checker.sv @@
// ----------------------------------------------------------------------------
// Frame parser port checker
// Watches the top-level ports for output ordering and status consistency.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_parser_unit_assert.svh"

module lpfp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [3:0]                     o_field_code,
    input logic [lpfp_pkg::OUT_OFF_W-1:0] o_field_offset,
    input logic [7:0]                     o_byte_out,
    input logic                           o_frame_end,
    input logic [2:0]                     o_status
);
    import lpfp_pkg::*;

    logic        r_expect_start;
    logic        w_out_take;
    logic        w_start_ok;
    logic        w_mid_item;
    logic        w_end_checked;
    logic        w_end_field_match;
    logic        w_out_stalled;
    logic [14:0] w_hold_bits;

    assign w_out_take        = o_valid && !i_stall;
    assign w_start_ok        = (o_field_code == F_MAGIC) && (o_field_offset == '0);
    assign w_mid_item        = o_valid && !o_frame_end;
    assign w_end_checked     = o_valid && o_frame_end
                               && ((o_status == ST_OK) || (o_status == ST_TRAILING));
    assign w_end_field_match = ((o_status == ST_OK) && (o_field_code == F_MAC))
                               || ((o_status == ST_TRAILING) && (o_field_code == F_EXCESS));
    assign w_out_stalled     = o_valid && i_stall;
    assign w_hold_bits       = {o_byte_out, o_field_code, o_status};

    // the first item after reset or after a frame end opens a new frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_start <= 1'b1;
        end else if (w_out_take) begin
            r_expect_start <= o_frame_end;
        end
    end

    `LPFP_ASSERT_SAME(a_frame_start, i_clk, i_rst_n, o_valid && r_expect_start, w_start_ok)
    `LPFP_ASSERT_SAME(a_status_only_at_end, i_clk, i_rst_n, w_mid_item, o_status == ST_OK)
    `LPFP_ASSERT_SAME(a_end_status_field, i_clk, i_rst_n, w_end_checked, w_end_field_match)
    `LPFP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, w_out_stalled, o_valid && $stable(w_hold_bits))

endmodule

bind length_prefixed_frame_parser_unit lpfp_checker u_lpfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_field_code   (o_field_code),
    .o_field_offset (o_field_offset),
    .o_byte_out     (o_byte_out),
    .o_frame_end    (o_frame_end),
    .o_status       (o_status)
);

@@ tb/length_prefixed_frame_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Length-prefixed frame parser testbench
// Streams directed and random frames through the parser under random input
// gaps and output stalls, and checks every labeled byte and frame status
// against a cycle-free model of the parser kept in this file.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_unit_tb;
    import lpfp_pkg::*;

    localparam int unsigned HDR_BYTES = DEF_MAGIC_BYTES + VERSION_BYTES + TYPE_BYTES +
                                        DEF_SESSION_BYTES + COUNTER_BYTES +
                                        DEF_NONCE_BYTES + LENGTH_BYTES;
    localparam int unsigned MIN_FRAME   = HDR_BYTES + DEF_TAG_BYTES + DEF_MAC_BYTES;
    localparam logic [31:0] PAY_LIMIT   = 32'd1 << DEF_MAX_PAYLOAD_LOG2;
    localparam int unsigned OFF_CAP     = 32'h01FF_FFFF;
    localparam int unsigned BODY_CAP    = 600;
    localparam int unsigned MAX_GAP     = 12;
    localparam int unsigned ITEM_TARGET = 1650;
    localparam int unsigned NUM_PHASES  = 6;
    localparam int unsigned DRAIN_WAIT  = 4;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_byte;

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_data_byte  = '0;
    logic                 i_frame_last = 1'b0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    logic [3:0]           o_field_code;
    logic [OUT_OFF_W-1:0] o_field_offset;
    logic [7:0]           o_byte_out;
    logic                 o_frame_end;
    logic [2:0]           o_status;
    logic                 i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata  = '0;

    length_prefixed_frame_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_frame_last   (i_frame_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_field_code   (o_field_code),
        .o_field_offset (o_field_offset),
        .o_byte_out     (o_byte_out),
        .o_frame_end    (o_frame_end),
        .o_status       (o_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // Parser model state and its copy of the registers
    t_field_code cur_field   = F_MAGIC;
    int unsigned field_off   = 0;
    logic [31:0] pay_len     = '0;
    int unsigned byte_cnt    = 0;
    bit          magic_err   = 1'b0;
    bit          version_err = 1'b0;
    logic [31:0] cfg_magic   = '0;
    logic [7:0]  cfg_version = '0;

    t_in_byte    byte_q[$];
    t_item       label_q[$];
    int unsigned queued_bytes = 0;
    int unsigned fails        = 0;
    int unsigned cycles       = 0;

    int unsigned gap_left  = 0;
    int unsigned gap_now;
    bit          src_burst = 1'b0;
    t_in_byte    next_byte;
    int unsigned stall_left = 0;
    int unsigned stall_now;
    bit          snk_burst  = 1'b0;
    t_item       want_item;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned field_len(t_field_code f);
        case (f)
            F_MAGIC:   return DEF_MAGIC_BYTES;
            F_VERSION: return VERSION_BYTES;
            F_TYPE:    return TYPE_BYTES;
            F_SESSION: return DEF_SESSION_BYTES;
            F_COUNTER: return COUNTER_BYTES;
            F_NONCE:   return DEF_NONCE_BYTES;
            F_LENGTH:  return LENGTH_BYTES;
            F_PAYLOAD: return pay_len;
            F_TAG:     return DEF_TAG_BYTES;
            F_MAC:     return DEF_MAC_BYTES;
            default:   return 0;
        endcase
    endfunction

    // Label one accepted byte and advance the parse state
    function automatic t_item label_byte(logic [7:0] b, logic last);
        t_item       r;
        t_field_code f;
        t_field_code nxt_field;
        int unsigned off;
        int unsigned pos;
        logic [7:0]  want;
        bit          mac_done;
        f        = cur_field;
        off      = field_off;
        mac_done = 1'b0;
        r.field_code   = f;
        r.field_offset = (off > OUT_OFF_MAX) ? OUT_OFF_MAX : OUT_OFF_W'(off);
        r.byte_out     = b;
        r.frame_end    = last;
        r.status       = ST_OK;
        case (f)
            F_MAGIC: begin
                // magic bytes past the register width must be zero
                pos  = DEF_MAGIC_BYTES - 1 - off;
                want = (pos < 4) ? 8'(cfg_magic >> (8 * pos)) : 8'h00;
                if (want != b) magic_err = 1'b1;
            end
            F_VERSION: begin
                if (cfg_version != b) version_err = 1'b1;
            end
            F_LENGTH: begin
                pay_len = {pay_len[23:0], b};
            end
            default: ;
        endcase
        if (byte_cnt < MIN_FRAME) byte_cnt++;
        if (f == F_EXCESS) begin
            if (off < OFF_CAP) off++;
        end else begin
            off++;
            if (off >= field_len(f)) begin
                nxt_field = t_field_code'(f + 4'd1);
                off       = 0;
                if (f == F_LENGTH) begin
                    if (pay_len > PAY_LIMIT) nxt_field = F_EXCESS;
                    else if (pay_len == 0) nxt_field = F_TAG;
                end
                if (f == F_MAC) mac_done = 1'b1;
                cur_field = nxt_field;
            end
        end
        field_off = off;
        if (last) begin
            if (byte_cnt < MIN_FRAME) r.status = ST_SHORT;
            else if (magic_err) r.status = ST_MAGIC;
            else if (version_err) r.status = ST_VERSION;
            else if (pay_len > PAY_LIMIT) r.status = ST_TOO_LARGE;
            else if (f == F_EXCESS) r.status = ST_TRAILING;
            else if (mac_done) r.status = ST_OK;
            else r.status = ST_TRUNC;
            cur_field   = F_MAGIC;
            field_off   = 0;
            pay_len     = '0;
            byte_cnt    = 0;
            magic_err   = 1'b0;
            version_err = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Byte source: hold a stalled item, otherwise wait out the gap and load the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                gap_now = src_burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
            end else begin
                gap_now = gap_left;
            end
            if (gap_now == 0 && byte_q.size() != 0) begin
                next_byte = byte_q.pop_front();
                i_data_byte  <= next_byte.data;
                i_frame_last <= next_byte.last;
                i_valid      <= 1'b1;
                gap_left     <= 0;
            end else begin
                i_valid  <= 1'b0;
                gap_left <= (gap_now != 0) ? gap_now - 1 : 0;
            end
        end
    end

    // Result sink: predict on input acceptance, compare on output acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (i_valid && !o_stall)
                label_q.insert(label_q.size(), label_byte(i_data_byte, i_frame_last));
            if (o_valid && !i_stall) begin
                if (label_q.size() == 0) begin
                    $error("unexpected item: field_code %0d, byte_out %0h",
                           o_field_code, o_byte_out);
                    fails++;
                end else begin
                    want_item = label_q.pop_front();
                    check_field("field_code", 32'(want_item.field_code), 32'(o_field_code));
                    check_field("field_offset", 32'(want_item.field_offset),
                                32'(o_field_offset));
                    check_field("byte_out", 32'(want_item.byte_out), 32'(o_byte_out));
                    check_field("frame_end", 32'(want_item.frame_end), 32'(o_frame_end));
                    check_field("status", 32'(want_item.status), 32'(o_status));
                end
                stall_now = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
                stall_left <= stall_now;
                i_stall    <= (stall_now != 0);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= (stall_left > 1);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_MAGIC) cfg_magic = data;
        else cfg_version = data[7:0];
    endtask

    task automatic set_regs(input logic [31:0] magic, input logic [7:0] version);
        write_reg(CFG_MAGIC, magic);
        // upper data bits are junk and must be dropped
        write_reg(CFG_VERSION, {24'($urandom), version});
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || i_valid || label_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic queue_bytes(ref logic [7:0] fr[$]);
        t_in_byte nb;
        foreach (fr[i]) begin
            nb.data = fr[i];
            nb.last = (i == fr.size() - 1);
            byte_q.insert(byte_q.size(), nb);
        end
        queued_bytes += fr.size();
    endtask

    // Build one frame from the current registers; cut != 0 truncates to cut bytes,
    // extra appends bytes after the mac
    task automatic queue_frame(input logic [31:0] len, input bit bad_magic,
                               input bit bad_version, input int unsigned cut,
                               input int unsigned extra);
        logic [7:0]  fr[$];
        int unsigned pos;
        int unsigned body;
        int unsigned spoil;
        for (int i = 0; i < DEF_MAGIC_BYTES; i++) begin
            pos = DEF_MAGIC_BYTES - 1 - i;
            fr.insert(fr.size(), (pos < 4) ? 8'(cfg_magic >> (8 * pos)) : 8'h00);
        end
        if (bad_magic) begin
            spoil     = $urandom_range(0, DEF_MAGIC_BYTES - 1);
            fr[spoil] = fr[spoil] ^ 8'($urandom_range(1, 255));
        end
        fr.insert(fr.size(),
                  bad_version ? cfg_version ^ 8'($urandom_range(1, 255)) : cfg_version);
        repeat (TYPE_BYTES + DEF_SESSION_BYTES + COUNTER_BYTES + DEF_NONCE_BYTES)
            fr.insert(fr.size(), 8'($urandom));
        for (int i = LENGTH_BYTES - 1; i >= 0; i--) fr.insert(fr.size(), len[8*i +: 8]);
        body = (len > PAY_LIMIT) ? 0 : ((len > BODY_CAP) ? BODY_CAP : len);
        body += DEF_TAG_BYTES + DEF_MAC_BYTES + extra;
        repeat (body) fr.insert(fr.size(), 8'($urandom));
        if (cut != 0) begin
            while (fr.size() > cut) void'(fr.pop_back());
        end
        queue_bytes(fr);
    endtask

    initial begin : stimulus
        int unsigned k;
        int unsigned sel;
        int unsigned total;
        int unsigned cut;
        int unsigned extra;
        int unsigned rand_base;
        int unsigned phase_goal;
        logic [31:0] len;
        bit          bm;
        bit          bv;
        logic [7:0]  noise[$];

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at the reset register values
        set_regs(32'h0000_0000, 8'h00);
        queue_frame(0, 1'b0, 1'b0, 1, 0);
        queue_frame(0, 1'b0, 1'b0, 0, 0);
        queue_frame(1, 1'b0, 1'b0, 0, 0);
        wait_drained();

        // Directed frames covering each status and its precedence
        set_regs(32'hFFFF_FFFF, 8'hFF);
        queue_frame(3, 1'b0, 1'b0, 0, 0);
        queue_frame(0, 1'b1, 1'b1, 50, 0);
        queue_frame(0, 1'b1, 1'b1, 0, 0);
        queue_frame(2, 1'b0, 1'b1, 0, 0);
        queue_frame(PAY_LIMIT + 1, 1'b0, 1'b0, 0, 0);
        queue_frame(32'hFFFF_FFFF, 1'b0, 1'b0, 0, 5);
        queue_frame(PAY_LIMIT, 1'b0, 1'b0, 120, 0);
        queue_frame(5, 1'b0, 1'b0, 96, 0);
        queue_frame(0, 1'b0, 1'b0, 0, 3);
        queue_frame(8, 1'b0, 1'b0, MIN_FRAME - 1, 0);
        queue_frame(8, 1'b0, 1'b0, MIN_FRAME, 0);

        // Spread the remaining item budget over the phases by running totals
        rand_base = queued_bytes;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                1:       set_regs(32'h0000_0000, 8'h00);
                2:       set_regs(32'hFFFF_FFFF, 8'hFF);
                default: set_regs($urandom, 8'($urandom));
            endcase
            phase_goal = rand_base + (ph + 1) * ((ITEM_TARGET - rand_base) / NUM_PHASES);
            while (queued_bytes < phase_goal) begin
                k     = $urandom_range(0, 99);
                sel   = $urandom_range(0, 19);
                len   = (sel == 0) ? 0 : ((sel < 16) ? $urandom_range(1, 24)
                                                     : $urandom_range(25, 300));
                total = MIN_FRAME + len;
                cut   = 0;
                extra = 0;
                bm    = 1'b0;
                bv    = 1'b0;
                if (k < 45) begin
                    // well-formed frame
                end else if (k < 57) begin
                    cut = $urandom_range(1, total - 1);
                end else if (k < 65) begin
                    extra = $urandom_range(1, 20);
                end else if (k < 72) begin
                    bm = 1'b1;
                    bv = $urandom_range(0, 1);
                    if ($urandom_range(0, 3) == 0) len = PAY_LIMIT + 1;
                    if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, total - 1);
                end else if (k < 79) begin
                    bv = 1'b1;
                    if ($urandom_range(0, 3) == 0) len = PAY_LIMIT + 1;
                end else if (k < 86) begin
                    sel   = $urandom_range(0, 2);
                    len   = (sel == 0) ? PAY_LIMIT + $urandom_range(1, 255) :
                            (sel == 1) ? ($urandom | 32'h0020_0000) : 32'hFFFF_FFFF;
                    extra = $urandom_range(0, 20);
                    if ($urandom_range(0, 2) == 0)
                        cut = $urandom_range(1, MIN_FRAME + extra - 1);
                end else if (k < 90) begin
                    // huge legal length: always truncated
                    len = $urandom_range(0, 1) ? PAY_LIMIT : $urandom_range(301, PAY_LIMIT);
                    cut = $urandom_range(40, 250);
                end else begin
                    noise.delete();
                    repeat ($urandom_range(1, 120)) noise.insert(noise.size(), 8'($urandom));
                    queue_bytes(noise);
                    continue;
                end
                queue_frame(len, bm, bv, cut, extra);
            end
        end

        wait_drained();
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
